/* sv/actg_pkg.sv */
// ----------------------------------------------------------------------------
// actg_pkg
// Shared types, character codes and tag string tables for the ANSI color
// to HTML converter.
// ----------------------------------------------------------------------------
package actg_pkg;

  localparam int unsigned MaxSegs = 4;

  localparam logic [7:0] ESC_BYTE    = 8'h1B;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;

  localparam logic [7:0] ATTR_RESET = 8'd0;
  localparam logic [7:0] ATTR_BLINK = 8'd5;
  localparam logic [7:0] ATTR_FG_LO = 8'd30;
  localparam logic [7:0] ATTR_FG_HI = 8'd37;

  typedef enum logic [4:0] {
    SEG_BYTE,
    SEG_ESC,
    SEG_QUOT,
    SEG_LT,
    SEG_GT,
    SEG_AMP,
    SEG_CLOSE_BLINK,
    SEG_CLOSE_FONT,
    SEG_OPEN_BLINK,
    SEG_FONT_GRAY,
    SEG_FONT_RED,
    SEG_FONT_GREEN,
    SEG_FONT_YELLOW,
    SEG_FONT_BLUE,
    SEG_FONT_FUCHSIA,
    SEG_FONT_AQUA,
    SEG_FONT_WHITE
  } seg_e;

  typedef struct packed {
    seg_e [MaxSegs-1:0] seg;
    logic [7:0]         lit;
    logic [2:0]         count;
  } plan_t;

  function automatic logic [4:0] seg_len(seg_e code);
    logic [4:0] len;
    case (code)
      SEG_BYTE:         len = 5'd1;
      SEG_ESC:          len = 5'd1;
      SEG_QUOT:         len = 5'd5;
      SEG_LT:           len = 5'd3;
      SEG_GT:           len = 5'd3;
      SEG_AMP:          len = 5'd4;
      SEG_CLOSE_BLINK:  len = 5'd8;
      SEG_CLOSE_FONT:   len = 5'd7;
      SEG_OPEN_BLINK:   len = 5'd7;
      SEG_FONT_GRAY:    len = 5'd17;
      SEG_FONT_RED:     len = 5'd16;
      SEG_FONT_GREEN:   len = 5'd18;
      SEG_FONT_YELLOW:  len = 5'd19;
      SEG_FONT_BLUE:    len = 5'd17;
      SEG_FONT_FUCHSIA: len = 5'd20;
      SEG_FONT_AQUA:    len = 5'd17;
      SEG_FONT_WHITE:   len = 5'd18;
      default:          len = 5'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] seg_char(seg_e code, logic [4:0] idx, logic [7:0] lit);
    logic [159:0] text;
    logic [4:0]   pos;
    logic [7:0]   ch;
    case (code)
      SEG_ESC:          text = 160'(ESC_BYTE);
      SEG_QUOT:         text = 160'("&quot");
      SEG_LT:           text = 160'("&lt");
      SEG_GT:           text = 160'("&gt");
      SEG_AMP:          text = 160'("&amp");
      SEG_CLOSE_BLINK:  text = 160'("</blink>");
      SEG_CLOSE_FONT:   text = 160'("</FONT>");
      SEG_OPEN_BLINK:   text = 160'("<blink>");
      SEG_FONT_GRAY:    text = 160'("<FONT color=gray>");
      SEG_FONT_RED:     text = 160'("<FONT color=red>");
      SEG_FONT_GREEN:   text = 160'("<FONT color=green>");
      SEG_FONT_YELLOW:  text = 160'("<FONT color=yellow>");
      SEG_FONT_BLUE:    text = 160'("<FONT color=blue>");
      SEG_FONT_FUCHSIA: text = 160'("<FONT color=fuchsia>");
      SEG_FONT_AQUA:    text = 160'("<FONT color=aqua>");
      SEG_FONT_WHITE:   text = 160'("<FONT color=white>");
      default:          text = 160'(lit);
    endcase
    pos = 5'(seg_len(code) - 5'd1 - idx);
    ch  = text[{pos, 3'b000} +: 8];
    return ch;
  endfunction

endpackage

/* sv/actg_decode.sv */
// ----------------------------------------------------------------------------
// actg_decode
// Escape sequence parser and tag state; turns one registered item into a
// short list of output segments.
// ----------------------------------------------------------------------------
module actg_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             operation_i,
  input  logic [7:0]       data_byte_i,
  input  logic             line_end_i,
  output actg_pkg::plan_t  plan_o
);

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_OPEN,
    MODE_DIGITS
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] param_q, param_d;
  logic       font_q, font_d;
  logic       blink_q, blink_d;

  function automatic actg_pkg::seg_e text_seg(logic [7:0] b);
    actg_pkg::seg_e s;
    case (b)
      actg_pkg::CH_QUOTE: s = actg_pkg::SEG_QUOT;
      actg_pkg::CH_LT:    s = actg_pkg::SEG_LT;
      actg_pkg::CH_GT:    s = actg_pkg::SEG_GT;
      actg_pkg::CH_AMP:   s = actg_pkg::SEG_AMP;
      default:            s = actg_pkg::SEG_BYTE;
    endcase
    return s;
  endfunction

  function automatic actg_pkg::seg_e font_seg(logic [2:0] idx);
    actg_pkg::seg_e s;
    case (idx)
      3'd0:    s = actg_pkg::SEG_FONT_GRAY;
      3'd1:    s = actg_pkg::SEG_FONT_RED;
      3'd2:    s = actg_pkg::SEG_FONT_GREEN;
      3'd3:    s = actg_pkg::SEG_FONT_YELLOW;
      3'd4:    s = actg_pkg::SEG_FONT_BLUE;
      3'd5:    s = actg_pkg::SEG_FONT_FUCHSIA;
      3'd6:    s = actg_pkg::SEG_FONT_AQUA;
      default: s = actg_pkg::SEG_FONT_WHITE;
    endcase
    return s;
  endfunction

  logic        is_digit;
  logic [11:0] acc;
  logic        act;
  logic [2:0]  n;

  always_comb begin
    is_digit = data_byte_i inside {[actg_pkg::CH_ZERO:actg_pkg::CH_NINE]};
    acc      = {4'b0, param_q} * 12'd10 + {8'b0, data_byte_i[3:0]};
    act      = 1'b0;
    n        = 3'd0;
    mode_d   = mode_q;
    param_d  = param_q;
    font_d   = font_q;
    blink_d  = blink_q;
    for (int i = 0; i < actg_pkg::MaxSegs; i++) begin
      plan_o.seg[i] = actg_pkg::SEG_BYTE;
    end
    plan_o.lit = data_byte_i;

    if (operation_i) begin
      if (blink_q) begin
        plan_o.seg[n[1:0]] = actg_pkg::SEG_CLOSE_BLINK;
        n = n + 3'd1;
      end
      if (font_q) begin
        plan_o.seg[n[1:0]] = actg_pkg::SEG_CLOSE_FONT;
        n = n + 3'd1;
      end
      mode_d  = MODE_TEXT;
      param_d = 8'd0;
      font_d  = 1'b0;
      blink_d = 1'b0;
    end else if (data_byte_i == 8'd0) begin
      if (line_end_i) begin
        if (mode_q == MODE_ESC) begin
          plan_o.seg[n[1:0]] = actg_pkg::SEG_ESC;
          n = n + 3'd1;
        end
        mode_d  = MODE_TEXT;
        param_d = 8'd0;
      end
    end else begin
      case (mode_q)
        MODE_TEXT: begin
          if (data_byte_i == actg_pkg::ESC_BYTE && !line_end_i) begin
            mode_d = MODE_ESC;
          end else begin
            plan_o.seg[n[1:0]] = text_seg(data_byte_i);
            n = n + 3'd1;
          end
        end
        MODE_ESC: begin
          if (data_byte_i == actg_pkg::CH_LBRACKET) begin
            mode_d  = MODE_OPEN;
            param_d = 8'd0;
          end else begin
            plan_o.seg[n[1:0]] = actg_pkg::SEG_ESC;
            n = n + 3'd1;
            if (data_byte_i == actg_pkg::ESC_BYTE && !line_end_i) begin
              mode_d = MODE_ESC;
            end else begin
              mode_d = MODE_TEXT;
              plan_o.seg[n[1:0]] = text_seg(data_byte_i);
              n = n + 3'd1;
            end
          end
        end
        MODE_OPEN: begin
          if (is_digit) begin
            param_d = {4'b0, data_byte_i[3:0]};
            mode_d  = MODE_DIGITS;
          end else begin
            mode_d = MODE_TEXT;
          end
        end
        default: begin
          if (is_digit) begin
            param_d = (acc > 12'd255) ? 8'd255 : acc[7:0];
          end else begin
            param_d = 8'd0;
            act     = line_end_i ? (data_byte_i == actg_pkg::CH_M) : 1'b1;
            mode_d  = (!line_end_i && data_byte_i == actg_pkg::CH_SEMI) ? MODE_OPEN
                                                                       : MODE_TEXT;
          end
        end
      endcase

      if (act) begin
        if (param_q == actg_pkg::ATTR_BLINK) begin
          if (!blink_q) begin
            blink_d = 1'b1;
            plan_o.seg[n[1:0]] = actg_pkg::SEG_OPEN_BLINK;
            n = n + 3'd1;
          end
        end else if (param_q == actg_pkg::ATTR_RESET ||
                     param_q inside {[actg_pkg::ATTR_FG_LO:actg_pkg::ATTR_FG_HI]}) begin
          if (blink_q) begin
            plan_o.seg[n[1:0]] = actg_pkg::SEG_CLOSE_BLINK;
            n = n + 3'd1;
          end
          if (font_q) begin
            plan_o.seg[n[1:0]] = actg_pkg::SEG_CLOSE_FONT;
            n = n + 3'd1;
          end
          if (param_q == actg_pkg::ATTR_RESET) begin
            font_d  = 1'b0;
            blink_d = 1'b0;
          end else begin
            plan_o.seg[n[1:0]] = font_seg(param_q[2:0] - 3'd6);
            n = n + 3'd1;
            if (blink_q) begin
              plan_o.seg[n[1:0]] = actg_pkg::SEG_OPEN_BLINK;
              n = n + 3'd1;
            end
            font_d = 1'b1;
          end
        end
      end

      if (line_end_i) begin
        mode_d  = MODE_TEXT;
        param_d = 8'd0;
      end
    end
    plan_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      param_q <= 8'd0;
      font_q  <= 1'b0;
      blink_q <= 1'b0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      param_q <= param_d;
      font_q  <= font_d;
      blink_q <= blink_d;
    end
  end

endmodule

/* sv/actg_stream.sv */
// ----------------------------------------------------------------------------
// actg_stream
// Holds one segment list and sends its bytes, one per cycle while the output
// is not stalled, through the output register.
// ----------------------------------------------------------------------------
module actg_stream (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             plan_valid_i,
  output logic             plan_ready_o,
  input  actg_pkg::plan_t  plan_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);

  actg_pkg::seg_e [actg_pkg::MaxSegs-1:0] seg_q, seg_d;
  logic [7:0] lit_q, lit_d;
  logic [2:0] nseg_q, nseg_d;
  logic [1:0] seg_idx_q, seg_idx_d;
  logic [4:0] char_idx_q, char_idx_d;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  actg_pkg::seg_e cur_seg;
  logic           seg_end;
  logic           run_end;
  logic           out_free;
  logic           emit;
  logic           plan_take;

  always_comb begin
    cur_seg      = seg_q[seg_idx_q];
    seg_end      = (char_idx_q == 5'(actg_pkg::seg_len(cur_seg) - 5'd1));
    run_end      = seg_end && (seg_idx_q == 2'(nseg_q - 3'd1));
    out_free     = !out_valid_q || out_ready_i;
    emit         = busy_q && out_free;
    plan_ready_o = !busy_q || (out_free && run_end);
    plan_take    = plan_valid_i && plan_ready_o;

    seg_d       = seg_q;
    lit_d       = lit_q;
    nseg_d      = nseg_q;
    seg_idx_d   = seg_idx_q;
    char_idx_d  = char_idx_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = actg_pkg::seg_char(cur_seg, char_idx_q, lit_q);
      out_last_d  = run_end;
      if (seg_end) begin
        char_idx_d = 5'd0;
        seg_idx_d  = seg_idx_q + 2'd1;
        busy_d     = !run_end;
      end else begin
        char_idx_d = char_idx_q + 5'd1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (plan_take) begin
      seg_d      = plan_i.seg;
      lit_d      = plan_i.lit;
      nseg_d     = plan_i.count;
      seg_idx_d  = 2'd0;
      char_idx_d = 5'd0;
      busy_d     = (plan_i.count != 3'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      seg_idx_q   <= 2'd0;
      char_idx_q  <= 5'd0;
      nseg_q      <= 3'd0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      seg_idx_q   <= seg_idx_d;
      char_idx_q  <= char_idx_d;
      nseg_q      <= nseg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q      <= seg_d;
    lit_q      <= lit_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({1'b0, seg_idx_q} < nseg_q))
    else $error("segment index beyond the run");

  a_char_in_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (char_idx_q < actg_pkg::seg_len(cur_seg)))
    else $error("character index beyond the segment");

  a_empty_plan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plan_take && plan_i.count == 3'd0) |=> !busy_q)
    else $error("empty run left the streamer busy");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && run_end && !plan_take) |=> (!busy_q && out_last_q))
    else $error("final byte did not close the run");
`endif

endmodule

/* sv/ansi_color_to_html_tags_core.sv */
// ----------------------------------------------------------------------------
// ansi_color_to_html_tags_core
// Converts text bytes with ANSI color escapes into HTML text bytes.
// ----------------------------------------------------------------------------
// Each item passes through the input register, then the segment register
// feeding the output register. An item producing more than one byte holds
// the byte streamer until its last byte is sent, so input transfers run one
// per cycle while each item yields at most one byte and the output is not
// stalled, and stall otherwise; items yielding no byte leave the streamer
// idle. Reset is asynchronous and clears the parser and tag state.
module ansi_color_to_html_tags_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] data_byte_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic            item_valid_q, item_valid_d;
  logic            op_q;
  logic [7:0]      byte_q;
  logic            le_q;
  logic            plan_ready;
  logic            in_take;
  actg_pkg::plan_t plan;

  assign in_ready_o = !item_valid_q || plan_ready;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_take) begin
      item_valid_d = 1'b1;
    end else if (plan_ready) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= operation_i;
      byte_q <= data_byte_i;
      le_q   <= line_end_i;
    end
  end

  actg_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (item_valid_q && plan_ready),
    .operation_i (op_q),
    .data_byte_i (byte_q),
    .line_end_i  (le_q),
    .plan_o      (plan)
  );

  actg_stream u_stream (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .plan_valid_i  (item_valid_q),
    .plan_ready_o  (plan_ready),
    .plan_i        (plan),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
